FILE: hdl/tpml_pkg.sv
// ----------------------------------------------------------------------------
// tpml_pkg
// Shared types and constants for the tree path minimum block.
// ----------------------------------------------------------------------------
package tpml_pkg;

  localparam int IDX_BITS = 10;
  localparam int OUT_BITS = 32;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SET_FULL,
    OP_SET_BAD,
    OP_INS0,
    OP_INS_DEP,
    OP_INS_RD,
    OP_INS_WR,
    OP_INS_END,
    OP_QD,
    OP_QORD,
    OP_Q1_RD,
    OP_Q1_DEP,
    OP_Q1_CMP,
    OP_QOK,
    OP_LVL_TOP,
    OP_Q2_RD,
    OP_Q2_CMP,
    OP_Q3_RD,
    OP_Q3_FIN,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic is_query;
    logic full;
    logic bad;
    logic u_eq_v;
    logic lvl_zero;
    logic lvl_last;
    logic lvl_over;
  } dp_stat_t;

endpackage

FILE: hdl/tpml_ram.sv
// ----------------------------------------------------------------------------
// tpml_ram
// Generic RAM, one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tpml_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: hdl/tpml_ctrl.sv
// ----------------------------------------------------------------------------
// tpml_ctrl
// Sequencer for inserts and path queries; drives datapath operations.
// ----------------------------------------------------------------------------
module tpml_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tpml_pkg::dp_stat_t stat,
  output tpml_pkg::dp_op_t   op
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_INS_DEP, S_INS_RD, S_INS_WR, S_INS_END,
    S_QORD, S_Q1_RD, S_Q1_DEP, S_Q1_CMP, S_QEQ, S_Q2_RD, S_Q2_CMP,
    S_Q3_RD, S_Q3_FIN, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    op            = tpml_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = tpml_pkg::OP_LOAD;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        priority if (!stat.is_query && stat.full) begin
          op        = tpml_pkg::OP_SET_FULL;
          state_nxt = S_EMIT;
        end else if (stat.bad) begin
          op        = tpml_pkg::OP_SET_BAD;
          state_nxt = S_EMIT;
        end else if (!stat.is_query) begin
          op        = tpml_pkg::OP_INS0;
          state_nxt = S_INS_DEP;
        end else begin
          op        = tpml_pkg::OP_QD;
          state_nxt = S_QORD;
        end
      end
      S_INS_DEP: begin
        op        = tpml_pkg::OP_INS_DEP;
        state_nxt = stat.lvl_over ? S_INS_END : S_INS_RD;
      end
      S_INS_RD: begin
        op        = tpml_pkg::OP_INS_RD;
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        op        = tpml_pkg::OP_INS_WR;
        state_nxt = stat.lvl_last ? S_INS_END : S_INS_RD;
      end
      S_INS_END: begin
        op        = tpml_pkg::OP_INS_END;
        state_nxt = S_EMIT;
      end
      S_QORD: begin
        op        = tpml_pkg::OP_QORD;
        state_nxt = S_Q1_RD;
      end
      S_Q1_RD: begin
        op        = tpml_pkg::OP_Q1_RD;
        state_nxt = S_Q1_DEP;
      end
      S_Q1_DEP: begin
        op        = tpml_pkg::OP_Q1_DEP;
        state_nxt = S_Q1_CMP;
      end
      S_Q1_CMP: begin
        op        = tpml_pkg::OP_Q1_CMP;
        state_nxt = stat.lvl_zero ? S_QEQ : S_Q1_RD;
      end
      S_QEQ: begin
        if (stat.u_eq_v) begin
          op        = tpml_pkg::OP_QOK;
          state_nxt = S_EMIT;
        end else begin
          op        = tpml_pkg::OP_LVL_TOP;
          state_nxt = S_Q2_RD;
        end
      end
      S_Q2_RD: begin
        op        = tpml_pkg::OP_Q2_RD;
        state_nxt = S_Q2_CMP;
      end
      S_Q2_CMP: begin
        op        = tpml_pkg::OP_Q2_CMP;
        state_nxt = stat.lvl_zero ? S_Q3_RD : S_Q2_RD;
      end
      S_Q3_RD: begin
        op        = tpml_pkg::OP_Q3_RD;
        state_nxt = S_Q3_FIN;
      end
      S_Q3_FIN: begin
        op        = tpml_pkg::OP_Q3_FIN;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // wait for the output register to drain
        if (!out_valid_r || out_ready) begin
          op            = tpml_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/tpml_dp.sv
// ----------------------------------------------------------------------------
// tpml_dp
// Datapath: lifting tables, depth store, working registers, result register.
// ----------------------------------------------------------------------------
module tpml_dp #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 10,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tpml_pkg::dp_op_t                    op,
  output tpml_pkg::dp_stat_t                  stat,
  input  logic                                in_action,
  input  logic [tpml_pkg::IDX_BITS-1:0]       in_parent_node,
  input  logic signed [31:0]                  in_edge_weight,
  input  logic [tpml_pkg::IDX_BITS-1:0]       in_node_u,
  input  logic [tpml_pkg::IDX_BITS-1:0]       in_node_v,
  output logic [1:0]                          out_status,
  output logic signed [tpml_pkg::OUT_BITS-1:0] out_min_weight
);

  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LAW = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int LCW = $clog2(LIFT_LEVELS + 1);
  localparam int AW  = NW + LAW;
  localparam int CW  = (NW + 1 > tpml_pkg::IDX_BITS) ? NW + 1 : tpml_pkg::IDX_BITS;
  localparam int WB  = WEIGHT_BITS;
  localparam logic signed [63:0] SENT64  = (64'sd1 <<< (WB - 1)) - 64'sd1;
  localparam logic signed [63:0] FLOOR64 = -SENT64 - 64'sd1;
  localparam logic signed [WB-1:0] SENT_W = {1'b0, {(WB-1){1'b1}}};
  localparam logic [LCW-1:0] LVL_TOP = LCW'(LIFT_LEVELS - 1);

  function automatic logic signed [WB-1:0] smin(input logic signed [WB-1:0] a,
                                               input logic signed [WB-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // working registers
  logic [NW:0]           cnt_r, cnt_nxt;
  logic [LCW-1:0]        lvl_r, lvl_nxt;
  logic                  act_r, act_nxt;
  logic                  bad_r, bad_nxt;
  logic [NW-1:0]         par_r, par_nxt;
  logic [NW-1:0]         u_r, u_nxt;
  logic [NW-1:0]         v_r, v_nxt;
  logic [NW-1:0]         du_r, du_nxt;
  logic [NW-1:0]         cur_anc_r, cur_anc_nxt;
  logic signed [WB-1:0]  w_r, w_nxt;
  logic signed [WB-1:0]  cur_min_r, cur_min_nxt;
  logic signed [WB-1:0]  res_r, res_nxt;
  logic signed [WB-1:0]  mv_r, mv_nxt;
  logic [NW-1:0]         up_r, up_nxt;
  logic [1:0]            st_r, st_nxt;
  logic [1:0]            ost_r, ost_nxt;
  logic signed [tpml_pkg::OUT_BITS-1:0] omw_r, omw_nxt;

  // table ports
  logic                  tw_en;
  logic [AW-1:0]         tw_addr;
  logic [NW-1:0]         tw_anc;
  logic signed [WB-1:0]  tw_min;
  logic [NW-1:0]         ta_node, tb_node;
  logic [LAW-1:0]        ta_lvl, tb_lvl;
  logic [NW-1:0]         anc_a_raw, anc_b_raw, anc_a, anc_b;
  logic [WB-1:0]         min_a_raw, min_b_raw;
  logic signed [WB-1:0]  min_a, min_b;
  logic                  troot_a_r, troot_b_r;

  logic                  dw_en;
  logic [NW-1:0]         dw_data;
  logic [NW-1:0]         da_node, db_node;
  logic [NW-1:0]         dep_a_raw, dep_b_raw, dep_a, dep_b;
  logic                  droot_a_r, droot_b_r;

  // input decode
  logic [CW-1:0]         par_e, u_e, v_e, cnt_e;
  logic signed [63:0]    ew64, sat64;
  logic signed [63:0]    res64;
  logic [LCW-1:0]        lvl_m1;

  assign par_e = CW'(in_parent_node);
  assign u_e   = CW'(in_node_u);
  assign v_e   = CW'(in_node_v);
  assign cnt_e = CW'(cnt_r);
  assign ew64  = 64'(in_edge_weight);
  assign sat64 = (ew64 > SENT64) ? SENT64 : ((ew64 < FLOOR64) ? FLOOR64 : ew64);
  assign res64 = 64'(res_r);
  assign lvl_m1 = lvl_r - 1'b1;

  // node 0 rows are fixed; the stores are never written there
  assign anc_a = troot_a_r ? '0 : anc_a_raw;
  assign anc_b = troot_b_r ? '0 : anc_b_raw;
  assign min_a = troot_a_r ? SENT_W : $signed(min_a_raw);
  assign min_b = troot_b_r ? SENT_W : $signed(min_b_raw);
  assign dep_a = droot_a_r ? '0 : dep_a_raw;
  assign dep_b = droot_b_r ? '0 : dep_b_raw;

  assign stat.is_query = act_r;
  assign stat.full     = (cnt_r == (NW+1)'(MAX_NODES));
  assign stat.bad      = bad_r;
  assign stat.u_eq_v   = (u_r == v_r);
  assign stat.lvl_zero = (lvl_r == '0);
  assign stat.lvl_last = (lvl_r == LVL_TOP);
  assign stat.lvl_over = (lvl_r >= LCW'(LIFT_LEVELS));

  assign out_status     = ost_r;
  assign out_min_weight = omw_r;

  always_comb begin
    cnt_nxt     = cnt_r;
    lvl_nxt     = lvl_r;
    act_nxt     = act_r;
    bad_nxt     = bad_r;
    par_nxt     = par_r;
    u_nxt       = u_r;
    v_nxt       = v_r;
    du_nxt      = du_r;
    cur_anc_nxt = cur_anc_r;
    w_nxt       = w_r;
    cur_min_nxt = cur_min_r;
    res_nxt     = res_r;
    mv_nxt      = mv_r;
    up_nxt      = up_r;
    st_nxt      = st_r;
    ost_nxt     = ost_r;
    omw_nxt     = omw_r;
    tw_en       = 1'b0;
    tw_addr     = {cnt_r[NW-1:0], lvl_r[LAW-1:0]};
    tw_anc      = cur_anc_r;
    tw_min      = cur_min_r;
    ta_node     = v_r;
    ta_lvl      = lvl_r[LAW-1:0];
    tb_node     = v_r;
    tb_lvl      = lvl_r[LAW-1:0];
    dw_en       = 1'b0;
    dw_data     = NW'(dep_a + 1'b1);
    da_node     = u_r;
    db_node     = v_r;
    unique case (op)
      tpml_pkg::OP_NONE: ;
      tpml_pkg::OP_LOAD: begin
        act_nxt = in_action;
        bad_nxt = in_action ? ((u_e >= cnt_e) || (v_e >= cnt_e)) : (par_e >= cnt_e);
        par_nxt = par_e[NW-1:0];
        u_nxt   = u_e[NW-1:0];
        v_nxt   = v_e[NW-1:0];
        w_nxt   = WB'(sat64);
      end
      tpml_pkg::OP_SET_FULL: begin
        st_nxt  = tpml_pkg::ST_FULL;
        res_nxt = '0;
      end
      tpml_pkg::OP_SET_BAD: begin
        st_nxt  = tpml_pkg::ST_BAD;
        res_nxt = '0;
      end
      tpml_pkg::OP_INS0: begin
        tw_en       = 1'b1;
        tw_addr     = {cnt_r[NW-1:0], LAW'(0)};
        tw_anc      = par_r;
        tw_min      = w_r;
        da_node     = par_r;
        cur_anc_nxt = par_r;
        cur_min_nxt = w_r;
        lvl_nxt     = LCW'(1);
      end
      tpml_pkg::OP_INS_DEP: begin
        dw_en = 1'b1;
      end
      tpml_pkg::OP_INS_RD: begin
        ta_node = cur_anc_r;
        ta_lvl  = lvl_m1[LAW-1:0];
      end
      tpml_pkg::OP_INS_WR: begin
        tw_en       = 1'b1;
        tw_anc      = anc_a;
        tw_min      = smin(cur_min_r, min_a);
        cur_anc_nxt = anc_a;
        cur_min_nxt = smin(cur_min_r, min_a);
        lvl_nxt     = lvl_r + 1'b1;
      end
      tpml_pkg::OP_INS_END: begin
        cnt_nxt = cnt_r + 1'b1;
        st_nxt  = tpml_pkg::ST_OK;
        res_nxt = '0;
      end
      tpml_pkg::OP_QD: begin
        da_node = u_r;
        db_node = v_r;
      end
      tpml_pkg::OP_QORD: begin
        // keep v as the deeper endpoint
        if (dep_a > dep_b) begin
          u_nxt  = v_r;
          v_nxt  = u_r;
          du_nxt = dep_b;
        end else begin
          du_nxt = dep_a;
        end
        res_nxt = SENT_W;
        lvl_nxt = LVL_TOP;
      end
      tpml_pkg::OP_Q1_RD: begin
        ta_node = v_r;
      end
      tpml_pkg::OP_Q1_DEP: begin
        up_nxt  = anc_a;
        mv_nxt  = min_a;
        da_node = anc_a;
      end
      tpml_pkg::OP_Q1_CMP: begin
        if (dep_a >= du_r) begin
          res_nxt = smin(res_r, mv_r);
          v_nxt   = up_r;
        end
        if (lvl_r != '0) begin
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      tpml_pkg::OP_QOK: begin
        st_nxt = tpml_pkg::ST_OK;
      end
      tpml_pkg::OP_LVL_TOP: begin
        lvl_nxt = LVL_TOP;
      end
      tpml_pkg::OP_Q2_RD: begin
        ta_node = u_r;
        tb_node = v_r;
      end
      tpml_pkg::OP_Q2_CMP: begin
        if (anc_a != anc_b) begin
          res_nxt = smin(res_r, smin(min_a, min_b));
          u_nxt   = anc_a;
          v_nxt   = anc_b;
        end
        if (lvl_r != '0) begin
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      tpml_pkg::OP_Q3_RD: begin
        ta_node = u_r;
        ta_lvl  = '0;
        tb_node = v_r;
        tb_lvl  = '0;
      end
      tpml_pkg::OP_Q3_FIN: begin
        res_nxt = smin(res_r, smin(min_a, min_b));
        st_nxt  = tpml_pkg::ST_OK;
      end
      tpml_pkg::OP_EMIT: begin
        ost_nxt = st_r;
        omw_nxt = res64[tpml_pkg::OUT_BITS-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= (NW+1)'(1);
    end else begin
      cnt_r <= cnt_nxt;
    end
    lvl_r     <= lvl_nxt;
    act_r     <= act_nxt;
    bad_r     <= bad_nxt;
    par_r     <= par_nxt;
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    du_r      <= du_nxt;
    cur_anc_r <= cur_anc_nxt;
    w_r       <= w_nxt;
    cur_min_r <= cur_min_nxt;
    res_r     <= res_nxt;
    mv_r      <= mv_nxt;
    up_r      <= up_nxt;
    st_r      <= st_nxt;
    ost_r     <= ost_nxt;
    omw_r     <= omw_nxt;
    troot_a_r <= (ta_node == '0);
    troot_b_r <= (tb_node == '0);
    droot_a_r <= (da_node == '0);
    droot_b_r <= (db_node == '0);
  end

  tpml_ram #(.WIDTH(NW), .DEPTH(MAX_NODES << LAW)) u_anc_ram (
    .clk       (clk),
    .wr_en     (tw_en),
    .wr_addr   (tw_addr),
    .wr_data   (tw_anc),
    .rd_addr_a ({ta_node, ta_lvl}),
    .rd_data_a (anc_a_raw),
    .rd_addr_b ({tb_node, tb_lvl}),
    .rd_data_b (anc_b_raw)
  );

  tpml_ram #(.WIDTH(WB), .DEPTH(MAX_NODES << LAW)) u_min_ram (
    .clk       (clk),
    .wr_en     (tw_en),
    .wr_addr   (tw_addr),
    .wr_data   (tw_min),
    .rd_addr_a ({ta_node, ta_lvl}),
    .rd_data_a (min_a_raw),
    .rd_addr_b ({tb_node, tb_lvl}),
    .rd_data_b (min_b_raw)
  );

  tpml_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_dep_ram (
    .clk       (clk),
    .wr_en     (dw_en),
    .wr_addr   (cnt_r[NW-1:0]),
    .wr_data   (dw_data),
    .rd_addr_a (da_node),
    .rd_data_a (dep_a_raw),
    .rd_addr_b (db_node),
    .rd_data_b (dep_b_raw)
  );

endmodule

FILE: hdl/tree_path_min_binary_lifting_top.sv
// ----------------------------------------------------------------------------
// tree_path_min_binary_lifting_top
// Tree builder with binary-lifting path minimum queries.
// ----------------------------------------------------------------------------
// Input beats carry an action: insert (append the next node under a loaded
// parent with an edge weight) or query (minimum edge weight on the path
// between two loaded nodes). Each input beat yields exactly one output beat
// with a status and a weight.
// One item is worked on at a time; the next beat is taken once the result
// sits in the output register. The time an item takes is set by the lifting
// loops: one registered table read per level step, plus a depth read per step
// in the first query pass. An error (table full or bad index) skips the loops,
// and a query whose endpoints meet after the depth lift skips the second
// lifting pass and the final step.
// After reset only the root is loaded; its rows are fixed in logic, so no
// clearing pass is needed. If the receiver stalls, the finished result waits
// in the output register and the block holds in its emit step until it drains.
// ----------------------------------------------------------------------------
module tree_path_min_binary_lifting_top #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 10,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic [tpml_pkg::IDX_BITS-1:0]        in_parent_node,
  input  logic signed [31:0]                   in_edge_weight,
  input  logic [tpml_pkg::IDX_BITS-1:0]        in_node_u,
  input  logic [tpml_pkg::IDX_BITS-1:0]        in_node_v,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic signed [tpml_pkg::OUT_BITS-1:0] out_min_weight
);

  tpml_pkg::dp_op_t   op;
  tpml_pkg::dp_stat_t stat;

  tpml_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .op        (op)
  );

  tpml_dp #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .stat           (stat),
    .in_action      (in_action),
    .in_parent_node (in_parent_node),
    .in_edge_weight (in_edge_weight),
    .in_node_u      (in_node_u),
    .in_node_v      (in_node_v),
    .out_status     (out_status),
    .out_min_weight (out_min_weight)
  );

endmodule
